// ===== rtl/b10k_pkg.sv =====
// ----------------------------------------------------------------------------
// b10k_pkg
// Shared types and constants for the base-10000 numeric to scaled integer
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package b10k_pkg;

	localparam logic [1:0] OP_ABSENT = 2'd0;
	localparam logic [1:0] OP_HEADER = 2'd1;
	localparam logic [1:0] OP_DIGIT  = 2'd2;

	localparam logic [15:0] SIGN_MASK = 16'hC000;
	localparam logic [15:0] SIGN_NAN  = 16'hC000;
	localparam logic [15:0] SIGN_NEG  = 16'h4000;

	localparam logic [15:0] RADIX     = 16'd10000;
	localparam logic [13:0] MUL_10000 = 14'd10000;
	localparam logic [13:0] MUL_1000  = 14'd1000;
	localparam logic [13:0] MUL_100   = 14'd100;
	localparam logic [13:0] MUL_10    = 14'd10;

	// reciprocal constants, exact for digits below 10000
	localparam logic [15:0] DIV10_RECIP   = 16'd52429;
	localparam logic [12:0] DIV100_RECIP  = 13'd5243;
	localparam logic [13:0] DIV1000_RECIP = 14'd8389;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_PREP,
		ST_LO,
		ST_HI,
		ST_FIN,
		ST_NULL
	} state_t;

	typedef struct packed {
		logic load_hdr;
		logic drop;
		logic store;
		logic start;
		logic prep;
		logic mac_lo;
		logic mac_hi;
		logic load_res;
		logic load_null;
	} cmd_t;

	typedef struct packed {
		logic open;
		logic last;
		logic hdr_empty;
		logic nan;
		logic skip;
		logic more;
	} stat_t;

endpackage

`default_nettype wire

// ===== rtl/base10000_numeric_to_scaled_int.sv =====
// ----------------------------------------------------------------------------
// base10000_numeric_to_scaled_int
// Converts a base-10000 decimal number (header plus digit words) into a
// signed 128-bit integer scaled by 10^display_scale.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  in        in_valid / in_ready   opcode, digit_count, weight, sign_word,
//                                  display_scale, digit_word
//  out       out_valid / out_ready value_low, value_high, is_null, overflow,
//                                  bad_digit
//
// header and digit requests are accepted only while the block is idle; the
// request that closes a number starts the walk: start, prep, then one 64x14
// multiply-add per cycle, low half then high half, for each of n base-10000
// positions (1 <= n <= STEP_LIMIT), then finish; start goes to finish
// directly when no position is walked or the step limit is exceeded.
// a finished result waits in the output register; the walk of the next
// number only stalls at its last cycle if that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module base10000_numeric_to_scaled_int #(
	parameter int DIGIT_STORE_DEPTH = 16,
	parameter int STEP_LIMIT        = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic [1:0]         opcode,
	input  wire logic [14:0]        digit_count,
	input  wire logic signed [15:0] weight,
	input  wire logic [15:0]        sign_word,
	input  wire logic [13:0]        display_scale,
	input  wire logic signed [15:0] digit_word,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic [63:0]        value_low,
	output      logic signed [63:0] value_high,
	output      logic               is_null,
	output      logic               overflow,
	output      logic               bad_digit
);

	import b10k_pkg::*;

	cmd_t  cmd;
	stat_t st;

	b10k_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	b10k_dp #(
		.DIGIT_STORE_DEPTH (DIGIT_STORE_DEPTH),
		.STEP_LIMIT        (STEP_LIMIT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.digit_count   (digit_count),
		.weight        (weight),
		.sign_word     (sign_word),
		.display_scale (display_scale),
		.digit_word    (digit_word),
		.value_low     (value_low),
		.value_high    (value_high),
		.is_null       (is_null),
		.overflow      (overflow),
		.bad_digit     (bad_digit)
	);

endmodule

`default_nettype wire

// ===== rtl/b10k_ram.sv =====
// ----------------------------------------------------------------------------
// b10k_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module b10k_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ===== rtl/b10k_ctrl.sv =====
// ----------------------------------------------------------------------------
// b10k_ctrl
// Controller: request intake, conversion sequencing and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module b10k_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output      logic            in_ready,
	input  wire logic [1:0]      opcode,
	output      logic            out_valid,
	input  wire logic            out_ready,
	input  wire b10k_pkg::stat_t st,
	output      b10k_pkg::cmd_t  cmd
);

	import b10k_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_res || cmd.load_null) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (opcode)
						OP_ABSENT: begin
							cmd.drop = 1'b1;
							state_d  = ST_NULL;
						end
						OP_HEADER: begin
							cmd.load_hdr = 1'b1;
							if (st.hdr_empty) begin
								state_d = ST_START;
							end
						end
						OP_DIGIT: begin
							if (st.open) begin
								cmd.store = 1'b1;
								if (st.last) begin
									state_d = ST_START;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_START: begin
				cmd.start = 1'b1;
				priority if (st.nan) begin
					state_d = ST_NULL;
				end else if (st.skip) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_LO;
			end
			ST_LO: begin
				cmd.mac_lo = 1'b1;
				state_d    = ST_HI;
			end
			ST_HI: begin
				cmd.mac_hi = 1'b1;
				if (st.more) begin
					cmd.prep = 1'b1;
					state_d  = ST_LO;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.load_res = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_NULL: begin
				if (out_free) begin
					cmd.load_null = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/b10k_dp.sv =====
// ----------------------------------------------------------------------------
// b10k_dp
// Datapath: header registers, digit store, two-half multiply-accumulate of
// the 128-bit magnitude, sign and range handling, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module b10k_dp #(
	parameter int DIGIT_STORE_DEPTH = 16,
	parameter int STEP_LIMIT        = 10
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire b10k_pkg::cmd_t     cmd,
	output      b10k_pkg::stat_t    st,
	input  wire logic [14:0]        digit_count,
	input  wire logic signed [15:0] weight,
	input  wire logic [15:0]        sign_word,
	input  wire logic [13:0]        display_scale,
	input  wire logic signed [15:0] digit_word,
	output      logic [63:0]        value_low,
	output      logic signed [63:0] value_high,
	output      logic               is_null,
	output      logic               overflow,
	output      logic               bad_digit
);

	import b10k_pkg::*;

	localparam int AW = $clog2(DIGIT_STORE_DEPTH);
	localparam int SW = $clog2(STEP_LIMIT + 1);

	// header state
	logic [14:0]        left_q;
	logic [14:0]        total_q;
	logic signed [15:0] weight_q;
	logic [13:0]        scale_q;
	logic               neg_q;
	logic               nan_q;

	// walk state
	logic signed [16:0] idx_q;
	logic [SW-1:0]      steps_q;
	logic [SW-1:0]      int_left_q;
	logic [13:0]        frac_scale_q;
	logic [13:0]        add_q;
	logic [13:0]        mul_q;
	logic [63:0]        mag_lo_q;
	logic [63:0]        mag_hi_q;
	logic [13:0]        carry_q;
	logic               mac_ovf_q;
	logic               bad_q;
	logic               ovf_q;
	logic               range_q;

	// start values
	logic signed [16:0] w_ext;
	logic [16:0]        nint;
	logic signed [16:0] idx0;
	logic [12:0]        nfrac;
	logic [17:0]        steps_sum;
	logic               limit;

	// digit store access
	logic [14:0]        wr_idx;
	logic               wr_en;
	logic signed [16:0] rd_idx;
	logic [15:0]        rd_u;
	logic               rd_in_range;
	logic [15:0]        rd_data;

	// step preparation
	logic               bad_raw;
	logic [13:0]        dig;
	logic [29:0]        p10;
	logic [26:0]        p100;
	logic [27:0]        p1000;
	logic [13:0]        prep_add;
	logic [13:0]        prep_mul;

	// multiply-accumulate and finish
	logic [77:0]        lo_t;
	logic [77:0]        hi_t;
	logic [127:0]       mag;
	logic [127:0]       mag_neg;
	logic [127:0]       res;
	logic               neg_limit;
	logic               fin_ovf;

	assign w_ext     = {weight_q[15], weight_q};
	assign nint      = weight_q[15] ? 17'd0 : 17'(w_ext + 17'sd1);
	assign idx0      = weight_q[15] ? (w_ext + 17'sd1) : 17'sd0;
	assign nfrac     = 13'(({1'b0, scale_q} + 15'd3) >> 2);
	assign steps_sum = {1'b0, nint} + {5'b0, nfrac};
	assign limit     = steps_sum > 18'(STEP_LIMIT);

	assign st.open      = left_q != 15'd0;
	assign st.last      = left_q == 15'd1;
	assign st.hdr_empty = digit_count == 15'd0;
	assign st.nan       = nan_q;
	assign st.skip      = limit || (steps_sum == 18'd0);
	assign st.more      = steps_q != '0;

	assign wr_idx = total_q - left_q;
	assign wr_en  = cmd.store && (wr_idx < 15'(DIGIT_STORE_DEPTH));

	assign rd_idx      = cmd.start ? idx0 : idx_q;
	assign rd_u        = rd_idx[15:0];
	assign rd_in_range = !rd_idx[16] && (rd_u < {1'b0, total_q})
		&& (rd_u < 16'(DIGIT_STORE_DEPTH));

	b10k_ram #(
		.WIDTH (16),
		.DEPTH (DIGIT_STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_idx[AW-1:0]),
		.wr_data (digit_word),
		.rd_addr (rd_u[AW-1:0]),
		.rd_data (rd_data)
	);

	assign bad_raw = rd_data[15] || (rd_data >= RADIX);
	assign dig     = (range_q && !bad_raw) ? rd_data[13:0] : 14'd0;
	assign p10     = 30'(dig) * 30'(DIV10_RECIP);
	assign p100    = 27'(dig) * 27'(DIV100_RECIP);
	assign p1000   = 28'(dig) * 28'(DIV1000_RECIP);

	always_comb begin
		prep_mul = MUL_10000;
		prep_add = dig;
		if (int_left_q == '0 && frac_scale_q < 14'd4) begin
			unique case (frac_scale_q[1:0])
				2'd3: begin
					prep_mul = MUL_1000;
					prep_add = 14'(p10[29:19]);
				end
				2'd2: begin
					prep_mul = MUL_100;
					prep_add = 14'(p100[26:19]);
				end
				2'd1: begin
					prep_mul = MUL_10;
					prep_add = 14'(p1000[27:23]);
				end
				default: begin
				end
			endcase
		end
	end

	assign lo_t = 78'(mag_lo_q) * 78'(mul_q) + 78'(add_q);
	assign hi_t = 78'(mag_hi_q) * 78'(mul_q) + 78'(carry_q);

	assign mag       = {mag_hi_q, mag_lo_q};
	assign mag_neg   = ~mag + 128'd1;
	assign neg_limit = neg_q && (mag_hi_q == 64'h8000_0000_0000_0000)
		&& (mag_lo_q == 64'd0);
	assign fin_ovf   = ovf_q || mac_ovf_q || (mag_hi_q[63] && !neg_limit);
	assign res       = fin_ovf ? 128'd0 : (neg_q ? mag_neg : mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			total_q  <= '0;
			weight_q <= '0;
			scale_q  <= '0;
			neg_q    <= 1'b0;
			nan_q    <= 1'b0;
		end else begin
			if (cmd.load_hdr) begin
				left_q   <= digit_count;
				total_q  <= digit_count;
				weight_q <= weight;
				scale_q  <= display_scale;
				nan_q    <= (sign_word & SIGN_MASK) == SIGN_NAN;
				neg_q    <= ((sign_word & SIGN_MASK) != SIGN_NAN)
					&& ((sign_word & SIGN_NEG) != 16'd0);
			end else if (cmd.drop) begin
				left_q <= '0;
			end else if (cmd.store) begin
				left_q <= left_q - 15'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		range_q <= rd_in_range;
		if (cmd.start) begin
			idx_q        <= idx0;
			steps_q      <= steps_sum[SW-1:0];
			int_left_q   <= nint[SW-1:0];
			frac_scale_q <= scale_q;
			mag_lo_q     <= '0;
			mag_hi_q     <= '0;
			carry_q      <= '0;
			mac_ovf_q    <= 1'b0;
			bad_q        <= 1'b0;
			ovf_q        <= limit;
		end
		if (cmd.prep) begin
			add_q   <= prep_add;
			mul_q   <= prep_mul;
			idx_q   <= idx_q + 17'sd1;
			steps_q <= steps_q - SW'(1);
			if (range_q && bad_raw) begin
				bad_q <= 1'b1;
			end
			if (int_left_q != '0) begin
				int_left_q <= int_left_q - SW'(1);
			end else begin
				frac_scale_q <= frac_scale_q - 14'd4;
			end
		end
		if (cmd.mac_lo) begin
			mag_lo_q <= lo_t[63:0];
			carry_q  <= lo_t[77:64];
		end
		if (cmd.mac_hi) begin
			mag_hi_q <= hi_t[63:0];
			if (hi_t[77:64] != 14'd0) begin
				mac_ovf_q <= 1'b1;
			end
		end
		if (cmd.load_res) begin
			value_low  <= res[63:0];
			value_high <= res[127:64];
			is_null    <= 1'b0;
			overflow   <= fin_ovf;
			bad_digit  <= bad_q;
		end else if (cmd.load_null) begin
			value_low  <= '0;
			value_high <= '0;
			is_null    <= 1'b1;
			overflow   <= 1'b0;
			bad_digit  <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== verif/base10000_numeric_to_scaled_int_test.sv =====
// ----------------------------------------------------------------------------
// base10000_numeric_to_scaled_int_test
// Self-checking bench for the base-10000 to scaled 128-bit converter. A short
// table of directed requests is followed by random numbers, broken sequences
// and noise. Every accepted request updates an in-bench model of the number
// in progress. Each finished number or absent value queues its scaled value,
// and every accepted result is compared field by field with the oldest entry.
// Both sides idle at random, and the result side stalls once for a long
// stretch so that the input backs up.
// ----------------------------------------------------------------------------
module base10000_numeric_to_scaled_int_test;
	timeunit 1ns;
	timeprecision 1ps;

	import b10k_pkg::*;

	localparam int DIGIT_DEPTH = 16;
	localparam int STEPS = 10;
	localparam int ITEM_TARGET = 600;
	localparam int CALM_ITEMS = 60;
	localparam int HOLD_AFTER = 150;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 64;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [63:0] lo;
		logic [63:0] hi;
		logic        is_null;
		logic        ovf;
		logic        bad;
	} conv_result_t;

	typedef struct packed {
		logic [1:0]   op;
		logic [14:0]  cnt;
		logic [15:0]  w;
		logic [15:0]  sw;
		logic [13:0]  sc;
		logic [15:0]  dw;
		logic         typed;
		conv_result_t want;
	} plan_row_t;

	localparam conv_result_t NO_RES   = '0;
	localparam conv_result_t ZERO_RES = '0;
	localparam conv_result_t NULL_RES = '{64'd0, 64'd0, 1'b1, 1'b0, 1'b0};
	localparam conv_result_t OVF_RES  = '{64'd0, 64'd0, 1'b0, 1'b1, 1'b0};
	localparam conv_result_t BAD_RES  = '{64'd0, 64'd0, 1'b0, 1'b0, 1'b1};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         opcode = '0;
	logic [14:0]        digit_count = '0;
	logic signed [15:0] weight = '0;
	logic [15:0]        sign_word = '0;
	logic [13:0]        display_scale = '0;
	logic signed [15:0] digit_word = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [63:0]        value_low;
	logic signed [63:0] value_high;
	logic               is_null;
	logic               overflow;
	logic               bad_digit;

	// number in progress as the block should see it
	logic [15:0]        pend_digits [DIGIT_DEPTH];
	int                 num_left = 0;
	int                 num_total = 0;
	logic signed [15:0] num_weight = '0;
	int                 num_scale = 0;
	bit                 num_neg = 1'b0;
	bit                 num_nan = 1'b0;

	conv_result_t scaled_results_due [$];
	int           requests_used = 0;
	int           mismatches = 0;
	bit           calm_tail = 1'b0;
	bit           long_hold_done = 1'b0;

	// 2^127 in base-10000 groups, most significant first
	logic [15:0] pow2_127_groups [10] = '{16'd170, 16'd1411, 16'd8346, 16'd469,
		16'd2317, 16'd3168, 16'd7303, 16'd7158, 16'd8410, 16'd5728};

	plan_row_t plan_rows [26] = '{
		// stray digit and unused opcode, both ignored
		'{OP_DIGIT,  15'd0,     16'h0000, 16'h0000, 14'd0,     16'h0005, 1'b0, NO_RES},
		'{OP_UNUSED, 15'd32767, 16'hFFFF, 16'hFFFF, 14'd16383, 16'hFFFF, 1'b0, NO_RES},
		'{OP_ABSENT, 15'd0,     16'h0000, 16'h0000, 14'd0,     16'h0000, 1'b1, NULL_RES},
		'{OP_HEADER, 15'd0,     16'h0000, 16'hFFFF, 14'd0,     16'h0000, 1'b1, NULL_RES},
		'{OP_HEADER, 15'd0,     16'h0000, 16'h0000, 14'd0,     16'h0000, 1'b1, ZERO_RES},
		'{OP_HEADER, 15'd0,     16'h7FFF, 16'h0000, 14'd0,     16'h0000, 1'b1, OVF_RES},
		'{OP_HEADER, 15'd0,     16'h0000, 16'h0000, 14'd16383, 16'h0000, 1'b1, OVF_RES},
		// negative zero at the lowest weight
		'{OP_HEADER, 15'd0,     16'h8000, SIGN_NEG, 14'd40,    16'h0000, 1'b1, ZERO_RES},
		'{OP_HEADER, 15'd1,     16'h8000, 16'h0000, 14'd4,     16'h0000, 1'b0, NO_RES},
		'{OP_DIGIT,  15'd0,     16'h0000, 16'h0000, 14'd0,     16'd9999, 1'b1, ZERO_RES},
		'{OP_HEADER, 15'd1,     16'h0000, 16'h0000, 14'd0,     16'h0000, 1'b0, NO_RES},
		'{OP_DIGIT,  15'd0,     16'h0000, 16'h0000, 14'd0,     16'h7FFF, 1'b1, BAD_RES},
		'{OP_HEADER, 15'd1,     16'h0000, 16'h0000, 14'd0,     16'h0000, 1'b0, NO_RES},
		'{OP_DIGIT,  15'd0,     16'h0000, 16'h0000, 14'd0,     16'h8000, 1'b1, BAD_RES},
		// truncated fraction group, negative
		'{OP_HEADER, 15'd2,     16'h0000, SIGN_NEG, 14'd3,     16'h0000, 1'b0, NO_RES},
		'{OP_DIGIT,  15'd0,     16'h0000, 16'h0000, 14'd0,     16'd1234, 1'b0, NO_RES},
		'{OP_DIGIT,  15'd0,     16'h0000, 16'h0000, 14'd0,     16'd5678, 1'b0, NO_RES},
		// header mid-number, then top bits 10 read as positive
		'{OP_HEADER, 15'd2,     16'h0000, 16'h0000, 14'd2,     16'h0000, 1'b0, NO_RES},
		'{OP_DIGIT,  15'd0,     16'h0000, 16'h0000, 14'd0,     16'd42,   1'b0, NO_RES},
		'{OP_HEADER, 15'd1,     16'h0000, 16'h8000, 14'd1,     16'h0000, 1'b0, NO_RES},
		'{OP_DIGIT,  15'd0,     16'h0000, 16'h0000, 14'd0,     16'd9999, 1'b0, NO_RES},
		// absent mid-number
		'{OP_HEADER, 15'd32767, 16'h0000, 16'h0000, 14'd0,     16'h0000, 1'b0, NO_RES},
		'{OP_DIGIT,  15'd0,     16'h0000, 16'h0000, 14'd0,     16'd7,    1'b0, NO_RES},
		'{OP_ABSENT, 15'd0,     16'h0000, 16'h0000, 14'd0,     16'h0000, 1'b1, NULL_RES},
		// missing low digit reads as zero
		'{OP_HEADER, 15'd1,     16'h0001, 16'h0000, 14'd0,     16'h0000, 1'b0, NO_RES},
		'{OP_DIGIT,  15'd0,     16'h0000, 16'h0000, 14'd0,     16'd9999, 1'b0, NO_RES}
	};

	function automatic logic [13:0] digit_at(input int pos, inout bit bad);
		logic signed [15:0] v;
		if (pos < 0 || pos >= num_total || pos >= DIGIT_DEPTH)
			return 14'd0;
		v = pend_digits[pos];
		if (v < 0 || v > 9999) begin
			bad = 1'b1;
			return 14'd0;
		end
		return 14'(v);
	endfunction

	function automatic void mac_step(inout logic [127:0] mag, inout bit carry,
			input logic [13:0] mul, input logic [13:0] add);
		logic [143:0] prod;
		prod = {16'd0, mag} * {130'd0, mul} + {130'd0, add};
		if (prod[143:128] != 0)
			carry = 1'b1;
		mag = prod[127:0];
	endfunction

	function automatic conv_result_t scaled_value();
		conv_result_t r;
		int w, sc, n_int, n_frac, p, k;
		logic [127:0] mag;
		logic [13:0] d;
		bit carry, bad, ovf;
		r = '0;
		num_left = 0;
		if (num_nan) begin
			r.is_null = 1'b1;
			return r;
		end
		w = num_weight;
		sc = num_scale;
		n_int = (w >= 0) ? w + 1 : 0;
		n_frac = (sc + 3) / 4;
		if (n_int + n_frac > STEPS) begin
			r.ovf = 1'b1;
			return r;
		end
		mag = '0;
		carry = 1'b0;
		bad = 1'b0;
		for (p = 0; p < n_int; p++)
			mac_step(mag, carry, MUL_10000, digit_at(p, bad));
		for (k = 1; k <= n_frac; k++) begin
			d = digit_at(w + k, bad);
			if (sc >= 4)
				mac_step(mag, carry, MUL_10000, d);
			else if (sc == 3)
				mac_step(mag, carry, MUL_1000, d / 10);
			else if (sc == 2)
				mac_step(mag, carry, MUL_100, d / 100);
			else
				mac_step(mag, carry, MUL_10, d / 1000);
			sc -= 4;
		end
		ovf = carry;
		if (!ovf && mag[127] && !(num_neg && mag == {1'b1, 127'd0}))
			ovf = 1'b1;
		if (ovf)
			mag = '0;
		else if (num_neg)
			mag = -mag;
		r.lo = mag[63:0];
		r.hi = mag[127:64];
		r.ovf = ovf;
		r.bad = bad;
		return r;
	endfunction

	function automatic void track_request(input plan_row_t rq, output bit used,
			output bit closes, output conv_result_t res);
		int slot;
		used = 1'b1;
		closes = 1'b0;
		res = '0;
		case (rq.op)
			OP_ABSENT: begin
				num_left = 0;
				res.is_null = 1'b1;
				closes = 1'b1;
			end
			OP_HEADER: begin
				num_total = rq.cnt;
				num_left = rq.cnt;
				num_weight = rq.w;
				num_scale = rq.sc;
				num_nan = (rq.sw & SIGN_MASK) == SIGN_NAN;
				num_neg = !num_nan && (rq.sw & SIGN_NEG) != 0;
				if (num_left == 0) begin
					res = scaled_value();
					closes = 1'b1;
				end
			end
			OP_DIGIT: begin
				if (num_left == 0) begin
					used = 1'b0;
				end else begin
					slot = num_total - num_left;
					if (slot < DIGIT_DEPTH)
						pend_digits[slot] = rq.dw;
					num_left--;
					if (num_left == 0) begin
						res = scaled_value();
						closes = 1'b1;
					end
				end
			end
			default: used = 1'b0;
		endcase
	endfunction

	function automatic plan_row_t random_request(input logic [1:0] op);
		plan_row_t rq;
		rq.op = op;
		rq.cnt = 15'($urandom);
		rq.w = 16'($urandom);
		rq.sw = 16'($urandom);
		rq.sc = 14'($urandom);
		rq.dw = 16'($urandom);
		rq.typed = 1'b0;
		rq.want = '0;
		return rq;
	endfunction

	task automatic offer(input plan_row_t rq);
		bit used, closes;
		conv_result_t res;
		opcode <= rq.op;
		digit_count <= rq.cnt;
		weight <= rq.w;
		sign_word <= rq.sw;
		display_scale <= rq.sc;
		digit_word <= rq.dw;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		track_request(rq, used, closes, res);
		if (closes)
			scaled_results_due.insert(scaled_results_due.size(), rq.typed ? rq.want : res);
		if (used)
			requests_used++;
		calm_tail = requests_used >= ITEM_TARGET - CALM_ITEMS;
		if (!calm_tail && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic random_sequence(input int serial);
		plan_row_t hdr, row;
		int kind, w, n_int, cnt, reps, k;
		bit neg;
		kind = $urandom_range(0, 99);
		hdr = random_request(OP_HEADER);
		if (serial < 2 || kind < 3) begin
			// right at the edge of the signed range
			neg = (serial == 0) ? 1'b1 : (serial == 1) ? 1'b0 : 1'($urandom_range(0, 1));
			hdr.cnt = 15'd10;
			hdr.w = 16'd9;
			hdr.sc = 14'd0;
			hdr.sw = (hdr.sw & ~SIGN_MASK) | (neg ? SIGN_NEG : 16'h0000);
			offer(hdr);
			for (k = 0; k < 10; k++) begin
				row = random_request(OP_DIGIT);
				row.dw = pow2_127_groups[k];
				if (k == 9 && serial >= 2)
					row.dw = 16'(pow2_127_groups[9] - 1 + $urandom_range(0, 2));
				offer(row);
			end
		end else if (kind < 60) begin
			w = int'($urandom_range(0, 12)) - 3;
			n_int = (w >= 0) ? w + 1 : 0;
			hdr.w = 16'(w);
			if ($urandom_range(0, 9) == 0)
				hdr.sc = 14'($urandom_range(0, 60));
			else
				hdr.sc = 14'($urandom_range(0, (STEPS - n_int) * 4));
			cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 20) : $urandom_range(0, 10);
			hdr.cnt = 15'(cnt);
			if ((hdr.sw & SIGN_MASK) == SIGN_NAN && $urandom_range(0, 2) != 0)
				hdr.sw = hdr.sw & ~(SIGN_MASK & ~SIGN_NEG);
			offer(hdr);
			for (k = 0; k < cnt; k++) begin
				row = random_request(OP_DIGIT);
				case ($urandom_range(0, 19))
					0: ;
					1: row.dw = 16'd0;
					2: row.dw = 16'd9999;
					default: row.dw = 16'($urandom_range(0, 9999));
				endcase
				offer(row);
			end
		end else if (kind < 75) begin
			// cut short by the next header or an absent value
			offer(hdr);
			reps = $urandom_range(0, 3);
			for (k = 0; k < reps; k++)
				offer(random_request(OP_DIGIT));
			if ($urandom_range(0, 1))
				offer(random_request(OP_ABSENT));
		end else if (kind < 83) begin
			offer(random_request(OP_ABSENT));
		end else if (kind < 90) begin
			offer(random_request($urandom_range(0, 1) ? OP_UNUSED : OP_DIGIT));
		end else begin
			cnt = $urandom_range(0, 2);
			hdr.cnt = 15'(cnt);
			offer(hdr);
			for (k = 0; k < cnt; k++)
				offer(random_request(OP_DIGIT));
		end
	endtask

	task automatic check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", field, want, got);
			mismatches++;
		end
	endtask

	base10000_numeric_to_scaled_int #(
		.DIGIT_STORE_DEPTH(DIGIT_DEPTH),
		.STEP_LIMIT(STEPS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.digit_count(digit_count),
		.weight(weight),
		.sign_word(sign_word),
		.display_scale(display_scale),
		.digit_word(digit_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value_low(value_low),
		.value_high(value_high),
		.is_null(is_null),
		.overflow(overflow),
		.bad_digit(bad_digit)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin : request_driver
		int serial;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan_rows[i])
			offer(plan_rows[i]);
		serial = 0;
		while (requests_used < ITEM_TARGET) begin
			random_sequence(serial);
			serial++;
		end
		in_valid <= 1'b0;
		while (scaled_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && scaled_results_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : result_pacing
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!long_hold_done && requests_used >= HOLD_AFTER) begin
				// long stall so the block backs up into its input
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				long_hold_done = 1'b1;
			end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : result_checker
		conv_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (scaled_results_due.size() == 0) begin
				$error("result with none pending: low %h high %h null %b ovf %b bad %b",
					value_low, value_high, is_null, overflow, bad_digit);
				mismatches++;
			end else begin
				want = scaled_results_due.pop_front();
				check_field("value_low", want.lo, value_low);
				check_field("value_high", want.hi, value_high);
				check_field("is_null", {63'd0, want.is_null}, {63'd0, is_null});
				check_field("overflow", {63'd0, want.ovf}, {63'd0, overflow});
				check_field("bad_digit", {63'd0, want.bad}, {63'd0, bad_digit});
			end
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
